>>> sv/cpfm_pkg.sv
// Package for the capture period frequency meter.
// Holds request and response types, operation codes and shared constants.
// No dependencies.
`default_nettype none

package cpfm_pkg;

  localparam int unsigned OpW    = 2;
  localparam int unsigned CapW   = 16;
  localparam int unsigned FreqW  = 16;
  localparam int unsigned DivW   = 32;

  // Operation codes
  localparam logic [OpW-1:0] OP_OVERFLOW = 2'd0;
  localparam logic [OpW-1:0] OP_CAPTURE  = 2'd1;
  localparam logic [OpW-1:0] OP_REPORT   = 2'd2;

  localparam logic [DivW-1:0]  CLK_HZ_RESET = 32'd80000000;
  localparam logic [CapW-1:0]  COUNT_MAX    = 16'hFFFF;
  localparam logic [FreqW-1:0] FREQ_MAX     = 16'hFFFF;

  typedef struct packed {
    logic [OpW-1:0]  operation;
    logic [CapW-1:0] capture_value;
  } in_req_t;

  typedef struct packed {
    logic [FreqW-1:0] frequency_hz;
    logic             clipped;
    logic             no_period;
  } out_rsp_t;

  // Divider status seen by the sequencer in the top level
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

>>> sv/capture_period_frequency_meter.sv
// Capture period frequency meter: top level with event handling and output register.
// Depends on cpfm_pkg and cpfm_div.
//
// Usage: requests arrive on the in channel (in_valid_i, in_stall_o, in_req_i).
// An overflow request bumps a saturating 16-bit overflow count; a capture
// request stores the period {overflow count, captured value} and clears the
// count. Neither gives a response. Operation code 3 is dropped.
// A report request divides timer_clock_hz by the stored period and returns
// one response on the out channel (out_valid_o, out_stall_i, out_rsp_o).
// Reports use the single restoring divider: 32 iterations (one quotient bit each),
// then one output register load. in_stall_o is high while the divider is busy or
// holds a result, so a new report is not taken until the last one has left the
// divider; other requests go one per cycle while in_stall_o is low. If the receiver
// stalls, the response waits in the output register; new requests are still taken
// while the divider is idle, and a finished quotient waits in the divider. A zero
// period reports 0 with no_period set; quotients above 65535 report 65535 with
// clipped set. cfg_we_i writes timer_clock_hz; the user must write it only while
// idle, as the block does not enforce this. Reset clears the count and period and
// loads timer_clock_hz with 80000000.
`default_nettype none

module capture_period_frequency_meter (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [cpfm_pkg::DivW-1:0] cfg_wdata_i,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire cpfm_pkg::in_req_t         in_req_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output cpfm_pkg::out_rsp_t             out_rsp_o
);

  localparam int unsigned W  = cpfm_pkg::DivW;
  localparam int unsigned FW = cpfm_pkg::FreqW;
  localparam int unsigned CW = cpfm_pkg::CapW;

  logic [W-1:0]  clk_hz_q, clk_hz_d;
  logic [CW-1:0] ovf_q, ovf_d;
  logic [W-1:0]  period_q, period_d;
  logic          nop_q, nop_d;
  logic          out_valid_q, out_valid_d;
  cpfm_pkg::out_rsp_t out_rsp_q, out_rsp_d;

  cpfm_pkg::div_stat_t div_stat;
  logic [W-1:0]  quotient;
  logic          accept;
  logic          start;
  logic          out_free;
  logic          load;
  logic          over;

  assign in_stall_o = div_stat.busy;
  assign accept     = in_valid_i && !in_stall_o;
  assign start      = accept && (in_req_i.operation == cpfm_pkg::OP_REPORT);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign load       = div_stat.done && out_free;

  cpfm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .ack_i      (load),
    .dividend_i (clk_hz_q),
    .divisor_i  (period_q),
    .stat_o     (div_stat),
    .quotient_o (quotient)
  );

  // Apply configuration writes and event requests
  always_comb begin
    clk_hz_d = clk_hz_q;
    ovf_d    = ovf_q;
    period_d = period_q;
    nop_d    = nop_q;
    if (cfg_we_i) begin
      clk_hz_d = cfg_wdata_i;
    end
    if (accept) begin
      unique case (in_req_i.operation)
        cpfm_pkg::OP_OVERFLOW: begin
          if (ovf_q != cpfm_pkg::COUNT_MAX) begin
            ovf_d = ovf_q + CW'(1);
          end
        end
        cpfm_pkg::OP_CAPTURE: begin
          period_d = {ovf_q, in_req_i.capture_value};
          ovf_d    = '0;
        end
        cpfm_pkg::OP_REPORT: begin
          nop_d = (period_q == '0);
        end
        default: begin
        end
      endcase
    end
  end

  // Saturate the quotient and form the response
  assign over = |quotient[W-1:FW];

  always_comb begin
    out_rsp_d   = out_rsp_q;
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
      if (nop_q) begin
        out_rsp_d.frequency_hz = '0;
        out_rsp_d.clipped      = 1'b0;
        out_rsp_d.no_period    = 1'b1;
      end else begin
        out_rsp_d.frequency_hz = over ? cpfm_pkg::FREQ_MAX : quotient[FW-1:0];
        out_rsp_d.clipped      = over;
        out_rsp_d.no_period    = 1'b0;
      end
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clk_hz_q    <= cpfm_pkg::CLK_HZ_RESET;
      ovf_q       <= '0;
      period_q    <= '0;
      nop_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      clk_hz_q    <= clk_hz_d;
      ovf_q       <= ovf_d;
      period_q    <= period_d;
      nop_q       <= nop_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_rsp_q <= out_rsp_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  // A report occupies the divider on the next cycle
  a_report_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> in_stall_o)
    else $error("report accepted without divider busy");

  // A loaded response appears on the next cycle
  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> out_valid_o)
    else $error("response not presented after load");

  // A zero period never reports a frequency
  a_no_period: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.no_period |->
      (out_rsp_o.frequency_hz == '0) && !out_rsp_o.clipped)
    else $error("zero period reported nonzero frequency");

  // Clipping always reports the full-scale value
  a_clip_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.clipped |-> (out_rsp_o.frequency_hz == cpfm_pkg::FREQ_MAX))
    else $error("clipped response without full-scale frequency");

endmodule

`default_nettype wire

>>> sv/cpfm_div.sv
// Iterative 32-bit restoring divider, one quotient bit per cycle while running.
// Depends on cpfm_pkg for widths and the status struct.
`default_nettype none

module cpfm_div (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic                     ack_i,
  input  wire logic [cpfm_pkg::DivW-1:0] dividend_i,
  input  wire logic [cpfm_pkg::DivW-1:0] divisor_i,
  output cpfm_pkg::div_stat_t           stat_o,
  output logic [cpfm_pkg::DivW-1:0]     quotient_o
);

  localparam int unsigned W  = cpfm_pkg::DivW;
  localparam int unsigned CW = $clog2(W);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]    state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [W-1:0]  rem_q, rem_d;
  logic [W-1:0]  quo_q, quo_d;
  logic [W-1:0]  dvs_q, dvs_d;
  logic [W:0]    shifted;
  logic [W:0]    diff;

  // Shift in the next dividend bit and try a subtract
  assign shifted = {rem_q, quo_q[W-1]};
  assign diff    = shifted - {1'b0, dvs_q};

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    dvs_d   = dvs_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = S_RUN;
          count_d = CW'(W - 1);
          rem_d   = '0;
          quo_d   = dividend_i;
          dvs_d   = divisor_i;
        end
      end
      S_RUN: begin
        // Keep the difference when no borrow, record the quotient bit
        if (!diff[W]) begin
          rem_d = diff[W-1:0];
        end else begin
          rem_d = shifted[W-1:0];
        end
        quo_d   = {quo_q[W-2:0], ~diff[W]};
        count_d = count_q - CW'(1);
        if (count_q == '0) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (ack_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  // Datapath registers need no reset
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign stat_o.busy = (state_q != S_IDLE);
  assign stat_o.done = (state_q == S_DONE);
  assign quotient_o  = quo_q;

  // Start only arrives while idle
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !stat_o.busy)
    else $error("divider started while busy");

  // Finish only after the last iteration
  a_done_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(stat_o.done) |-> ($past(state_q) == S_RUN) && ($past(count_q) == '0))
    else $error("divider finished early");

  // Result holds until acknowledged
  a_done_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_o.done && !ack_i |=> stat_o.done && $stable(quotient_o))
    else $error("divider result dropped before ack");

endmodule

`default_nettype wire

>>> bench/cpfm_checker.sv
// Checker for the capture period frequency meter: watches the request, response
// and register channels, tracks the meter state and compares each response.
// Depends on cpfm_pkg.

module cpfm_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [cpfm_pkg::DivW-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  input  logic                      in_stall_i,
  input  cpfm_pkg::in_req_t         in_req_i,
  input  logic                      out_valid_i,
  input  logic                      out_stall_i,
  input  cpfm_pkg::out_rsp_t        out_rsp_i,
  output int unsigned               fail_count_o,
  output int unsigned               pending_o,
  output int unsigned               checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DivW  = cpfm_pkg::DivW;
  localparam int unsigned CapW  = cpfm_pkg::CapW;
  localparam int unsigned FreqW = cpfm_pkg::FreqW;

  logic [DivW-1:0]    timer_clock;
  logic [CapW-1:0]    overflow_count;
  logic [DivW-1:0]    period_ticks;
  cpfm_pkg::out_rsp_t pending_reports[$];
  int unsigned        pending_count;
  int unsigned        fails;
  int unsigned        checked;

  assign fail_count_o = fails;
  assign pending_o    = pending_count;
  assign checked_o    = checked;

  // Print one line per failure and count it
  task automatic report_mismatch(string msg);
    $display("[%0t] ERROR: %s", $time, msg);
    fails++;
  endtask

  // Frequency from timer clock and period, with zero-period and clip handling
  function automatic cpfm_pkg::out_rsp_t frequency_of(logic [DivW-1:0] clk_hz,
                                                      logic [DivW-1:0] ticks);
    cpfm_pkg::out_rsp_t rsp;
    logic [DivW-1:0]    quot;
    rsp = '0;
    if (ticks == '0) begin
      rsp.no_period = 1'b1;
    end else begin
      quot = clk_hz / ticks;
      if (quot > DivW'(cpfm_pkg::FREQ_MAX)) begin
        rsp.frequency_hz = cpfm_pkg::FREQ_MAX;
        rsp.clipped      = 1'b1;
      end else begin
        rsp.frequency_hz = quot[FreqW-1:0];
      end
    end
    return rsp;
  endfunction

  // Compare one accepted response with the oldest pending report
  task automatic check_response(cpfm_pkg::out_rsp_t got);
    cpfm_pkg::out_rsp_t want;
    if (pending_reports.size() == 0) begin
      report_mismatch($sformatf("response %0d/%0b/%0b with no report pending",
                                got.frequency_hz, got.clipped, got.no_period));
    end else begin
      want = pending_reports.pop_front();
      checked++;
      if (got.frequency_hz !== want.frequency_hz)
        report_mismatch($sformatf("frequency_hz want %0d got %0d",
                                  want.frequency_hz, got.frequency_hz));
      if (got.clipped !== want.clipped)
        report_mismatch($sformatf("clipped want %0b got %0b", want.clipped, got.clipped));
      if (got.no_period !== want.no_period)
        report_mismatch($sformatf("no_period want %0b got %0b", want.no_period, got.no_period));
    end
  endtask

  // Advance the meter state on each accepted request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timer_clock    = cpfm_pkg::CLK_HZ_RESET;
      overflow_count = '0;
      period_ticks   = '0;
      pending_reports.delete();
      pending_count  = 0;
    end else begin
      if (cfg_we_i) timer_clock = cfg_wdata_i;
      if (out_valid_i && !out_stall_i) check_response(out_rsp_i);
      if (in_valid_i && !in_stall_i) begin
        case (in_req_i.operation)
          cpfm_pkg::OP_OVERFLOW: begin
            if (overflow_count != cpfm_pkg::COUNT_MAX) overflow_count++;
          end
          cpfm_pkg::OP_CAPTURE: begin
            period_ticks   = {overflow_count, in_req_i.capture_value};
            overflow_count = '0;
          end
          cpfm_pkg::OP_REPORT: begin
            pending_reports.push_back(frequency_of(timer_clock, period_ticks));
          end
          default: ;
        endcase
      end
      pending_count = pending_reports.size();
    end
  end

endmodule

>>> bench/tb_capture_period_frequency_meter.sv
// Testbench top for the capture period frequency meter: clock, reset, request
// and register stimulus, receiver stalls, timeout and verdict.
// Depends on cpfm_pkg, capture_period_frequency_meter and cpfm_checker.

module tb_capture_period_frequency_meter;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned    OpW          = cpfm_pkg::OpW;
  localparam int unsigned    CapW         = cpfm_pkg::CapW;
  localparam int unsigned    DivW         = cpfm_pkg::DivW;
  localparam logic [OpW-1:0] OP_UNUSED    = 2'd3;
  localparam int unsigned    CycleLimit   = 1_500_000;
  localparam int unsigned    SettleCycles = 40;
  localparam int unsigned    PhaseItems   = 130;
  localparam int unsigned    Phases       = 8;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [DivW-1:0]    cfg_wdata;
  logic               in_valid;
  logic               in_stall;
  cpfm_pkg::in_req_t  in_req;
  logic               out_valid;
  logic               out_stall;
  cpfm_pkg::out_rsp_t out_rsp;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;

  bit          in_calm;
  bit          out_calm;
  int unsigned stall_left;
  int unsigned sent_items;
  int unsigned op_count[4];
  int unsigned clocks_written;

  capture_period_frequency_meter dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_rsp_o  (out_rsp)
  );

  cpfm_checker u_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_req_i    (in_req),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_rsp_i   (out_rsp),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Idle length: mostly short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 2);
    if (r < 92) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  // Receiver stalls in bursts, with calm stretches
  initial begin
    out_stall  = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left != 0) begin
        stall_left--;
      end else if (!out_calm && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
      end
      out_stall <= (stall_left != 0);
    end
  end

  // Drive one request and hold it until accepted; call at a falling edge
  task automatic send_req(logic [OpW-1:0] op, logic [CapW-1:0] cap);
    int unsigned gap;
    gap = 0;
    if (!in_calm && $urandom_range(0, 2) == 0) gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid                <= 1'b1;
    in_req.operation        <= op;
    in_req.capture_value    <= cap;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    op_count[op]++;
    if (op != OP_UNUSED) sent_items++;
  endtask

  // Count overflows, then capture the given timer value
  task automatic measure(int unsigned overflows, logic [CapW-1:0] cap);
    repeat (overflows) send_req(cpfm_pkg::OP_OVERFLOW, CapW'($urandom));
    send_req(cpfm_pkg::OP_CAPTURE, cap);
  endtask

  // Drop valid, wait for all reports to come back and let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  // Write the timer clock while idle
  task automatic set_timer_clock(logic [DivW-1:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    clocks_written++;
  endtask

  function automatic logic [DivW-1:0] pick_clock(int unsigned phase);
    case (phase)
      0:       return '1;
      1:       return 32'd1;
      2:       return cpfm_pkg::CLK_HZ_RESET;
      3:       return $urandom_range(1_000, 2_000_000);
      default: return ($urandom_range(0, 1) != 0) ? DivW'($urandom)
                                                  : DivW'($urandom_range(1_000_000, 400_000_000));
    endcase
  endfunction

  function automatic logic [CapW-1:0] pick_capture();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 4) return '0;
    if (r < 8) return 16'd1;
    if (r < 12) return '1;
    return CapW'($urandom);
  endfunction

  function automatic int unsigned pick_overflows();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 30);
    return $urandom_range(100, 300);
  endfunction

  // Hard stop if the run hangs
  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("Timeout after %0d cycles", CycleLimit);
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int unsigned phase;
    int unsigned phase_end;
    int unsigned r;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    in_req    = '0;
    in_calm   = 1'b1;
    out_calm  = 1'b1;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: zero period after reset, unused code, extremes, clip edge
    send_req(cpfm_pkg::OP_REPORT, '1);
    send_req(OP_UNUSED, '1);
    send_req(OP_UNUSED, '0);
    measure(0, '0);
    send_req(cpfm_pkg::OP_REPORT, '0);
    measure(0, 16'd1);
    send_req(cpfm_pkg::OP_REPORT, 16'h5555);
    measure(1, '1);
    send_req(cpfm_pkg::OP_REPORT, 16'hAAAA);
    measure(0, 16'd1221);
    send_req(cpfm_pkg::OP_REPORT, '0);
    measure(0, 16'd1220);
    send_req(cpfm_pkg::OP_REPORT, '0);
    measure(2, 16'h8000);
    send_req(cpfm_pkg::OP_REPORT, '0);

    // Directed: zero clock register, then the widest clock
    set_timer_clock('0);
    measure(0, 16'd5);
    send_req(cpfm_pkg::OP_REPORT, '0);
    set_timer_clock('1);
    send_req(cpfm_pkg::OP_REPORT, '0);
    measure(0, 16'd1);
    send_req(cpfm_pkg::OP_REPORT, '0);

    // Directed: long overflow run with a full-width captured value
    measure(250, '1);
    send_req(cpfm_pkg::OP_REPORT, '0);
    set_timer_clock(32'd1);
    send_req(cpfm_pkg::OP_REPORT, '0);

    // Random phases, each under its own timer clock
    for (phase = 0; phase < Phases; phase++) begin
      set_timer_clock(pick_clock(phase));
      in_calm   = ($urandom_range(0, 3) == 0);
      out_calm  = ($urandom_range(0, 3) == 0);
      phase_end = sent_items + PhaseItems;
      while (sent_items < phase_end) begin
        r = $urandom_range(0, 99);
        if (r < 75) begin
          measure(pick_overflows(), pick_capture());
          repeat ($urandom_range(1, 2)) send_req(cpfm_pkg::OP_REPORT, CapW'($urandom));
        end else if (r < 92) begin
          send_req(cpfm_pkg::OP_OVERFLOW + OpW'($urandom_range(0, 3)), CapW'($urandom));
        end else begin
          send_req(cpfm_pkg::OP_REPORT, CapW'($urandom));
        end
      end
    end

    drain();
    $display("Sent %0d overflow, %0d capture, %0d report and %0d unused-code requests",
             op_count[cpfm_pkg::OP_OVERFLOW], op_count[cpfm_pkg::OP_CAPTURE],
             op_count[cpfm_pkg::OP_REPORT], op_count[OP_UNUSED]);
    $display("Compared %0d responses over %0d timer clock settings", checked, clocks_written);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
